@@ hdl/tcp_op_pkg.sv @@
// ----------------------------------------------------------------------------
// TCP option parser package
// Parse phases, event codes, option kinds and the result record shared by
// the parser modules.
// ----------------------------------------------------------------------------
package tcp_op_pkg;

    typedef enum logic [1:0] {
        PH_KIND = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2,
        PH_STOP = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        EV_EOL     = 4'd0,
        EV_NOP     = 4'd1,
        EV_MSS     = 4'd2,
        EV_WSCALE  = 4'd3,
        EV_SACKOK  = 4'd4,
        EV_SACK    = 4'd5,
        EV_TS      = 4'd6,
        EV_UNKNOWN = 4'd7,
        EV_BADLEN  = 4'd8,
        EV_NOLEN   = 4'd9,
        EV_LENLT2  = 4'd10,
        EV_OVERRUN = 4'd11
    } event_t;

    localparam logic [7:0] KIND_EOL    = 8'd0;
    localparam logic [7:0] KIND_NOP    = 8'd1;
    localparam logic [7:0] KIND_MSS    = 8'd2;
    localparam logic [7:0] KIND_WSCALE = 8'd3;
    localparam logic [7:0] KIND_SACKOK = 8'd4;
    localparam logic [7:0] KIND_SACK   = 8'd5;
    localparam logic [7:0] KIND_TS     = 8'd8;

    localparam logic [7:0] LEN_MIN    = 8'd2;
    localparam logic [7:0] LEN_MSS    = 8'd4;
    localparam logic [7:0] LEN_WSCALE = 8'd3;
    localparam logic [7:0] LEN_SACKOK = 8'd2;
    localparam logic [7:0] LEN_TS     = 8'd10;

    typedef struct packed {
        logic [7:0] opt_byte;
        logic       last_byte;
    } byte_t;

    typedef struct packed {
        event_t      event_code;
        logic [7:0]  option_kind;
        logic [7:0]  option_length;
        logic [31:0] value_first;
        logic [31:0] value_second;
        logic        ends_parse;
    } result_t;

    // Classify a completed option from its kind, length and captured body.
    function automatic result_t finish_option(input logic [7:0] kind,
                                              input logic [7:0] len,
                                              input logic [63:0] cap,
                                              input logic last);
        result_t r;
        r.event_code    = EV_UNKNOWN;
        r.option_kind   = kind;
        r.option_length = len;
        r.value_first   = '0;
        r.value_second  = '0;
        r.ends_parse    = last;
        case (kind)
            KIND_MSS:
            begin
                if (len == LEN_MSS)
                begin
                    r.event_code  = EV_MSS;
                    r.value_first = {16'd0, cap[15:0]};
                end
                else
                begin
                    r.event_code = EV_BADLEN;
                end
            end
            KIND_WSCALE:
            begin
                if (len == LEN_WSCALE)
                begin
                    r.event_code  = EV_WSCALE;
                    r.value_first = {24'd0, cap[7:0]};
                end
                else
                begin
                    r.event_code = EV_BADLEN;
                end
            end
            KIND_SACKOK:
            begin
                r.event_code = (len == LEN_SACKOK) ? EV_SACKOK : EV_BADLEN;
            end
            KIND_SACK:
            begin
                r.event_code = EV_SACK;
            end
            KIND_TS:
            begin
                if (len == LEN_TS)
                begin
                    r.event_code   = EV_TS;
                    r.value_first  = cap[63:32];
                    r.value_second = cap[31:0];
                end
                else
                begin
                    r.event_code = EV_BADLEN;
                end
            end
            default:
            begin
                r.event_code = EV_UNKNOWN;
            end
        endcase
        return r;
    endfunction

endpackage

@@ hdl/tcp_op_byte_if.sv @@
// ----------------------------------------------------------------------------
// Option byte channel
// Valid/ready channel carrying one byte of the option area and its end flag.
// ----------------------------------------------------------------------------
interface tcp_op_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] opt_byte;
    logic       last_byte;

    modport source (output valid, output opt_byte, output last_byte, input ready);
    modport sink   (input valid, input opt_byte, input last_byte, output ready);
endinterface

@@ hdl/tcp_op_event_if.sv @@
// ----------------------------------------------------------------------------
// Option event channel
// Valid/ready channel carrying one parsed option event.
// ----------------------------------------------------------------------------
interface tcp_op_event_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_code;
    logic [7:0]  option_kind;
    logic [7:0]  option_length;
    logic [31:0] value_first;
    logic [31:0] value_second;
    logic        ends_parse;

    modport source (output valid, output event_code, output option_kind,
                    output option_length, output value_first, output value_second,
                    output ends_parse, input ready);
    modport sink   (input valid, input event_code, input option_kind,
                    input option_length, input value_first, input value_second,
                    input ends_parse, output ready);
endinterface

@@ hdl/tcp_op_in_reg.sv @@
// ----------------------------------------------------------------------------
// Input register
// Captures one option byte item and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module tcp_op_in_reg
    import tcp_op_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tcp_op_byte_if.sink   opt_stream,
    input  logic          take,
    output logic          valid,
    output byte_t         data
);

    logic  valid_reg;
    logic  valid_next;
    byte_t data_reg;
    logic  accept;

    assign opt_stream.ready = !valid_reg || take;
    assign accept           = opt_stream.valid && opt_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= '{opt_byte: opt_stream.opt_byte, last_byte: opt_stream.last_byte};
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

@@ hdl/tcp_op_parse.sv @@
// ----------------------------------------------------------------------------
// Option parse stage
// Holds the parse phase, kind, length, body count and body capture, and
// decodes each byte into at most one event.
// ----------------------------------------------------------------------------
module tcp_op_parse
    import tcp_op_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    byte_valid,
    input  byte_t   byte_data,
    input  logic    space,
    output logic    take,
    output logic    res_load,
    output result_t res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  count_reg, count_next;
    logic [63:0] cap_reg, cap_next;
    logic        has_res;
    logic [7:0]  b;
    logic        last;

    assign b    = byte_data.opt_byte;
    assign last = byte_data.last_byte;
    assign take = byte_valid && space;

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        len_next   = len_reg;
        count_next = count_reg;
        cap_next   = cap_reg;
        has_res    = 1'b0;
        res        = '{event_code: EV_EOL, option_kind: 8'd0, option_length: 8'd0,
                       value_first: 32'd0, value_second: 32'd0, ends_parse: 1'b0};
        case (phase_reg)
            PH_KIND:
            begin
                if (b == KIND_EOL)
                begin
                    has_res        = 1'b1;
                    res.ends_parse = 1'b1;
                    phase_next     = last ? PH_KIND : PH_STOP;
                end
                else if (b == KIND_NOP)
                begin
                    has_res         = 1'b1;
                    res.event_code  = EV_NOP;
                    res.option_kind = b;
                    res.ends_parse  = last;
                end
                else if (last)
                begin
                    has_res         = 1'b1;
                    res.event_code  = EV_NOLEN;
                    res.option_kind = b;
                    res.ends_parse  = 1'b1;
                end
                else
                begin
                    kind_next  = b;
                    len_next   = 8'd0;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                len_next   = b;
                count_next = 8'd0;
                cap_next   = 64'd0;
                if (b < LEN_MIN)
                begin
                    has_res           = 1'b1;
                    res.event_code    = EV_LENLT2;
                    res.option_kind   = kind_reg;
                    res.option_length = b;
                    res.ends_parse    = 1'b1;
                    phase_next        = last ? PH_KIND : PH_STOP;
                end
                else if (b == LEN_MIN)
                begin
                    has_res    = 1'b1;
                    res        = finish_option(kind_reg, b, 64'd0, last);
                    phase_next = PH_KIND;
                end
                else if (last)
                begin
                    has_res           = 1'b1;
                    res.event_code    = EV_OVERRUN;
                    res.option_kind   = kind_reg;
                    res.option_length = b;
                    res.ends_parse    = 1'b1;
                    phase_next        = PH_KIND;
                end
                else
                begin
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                cap_next   = {cap_reg[55:0], b};
                count_next = count_reg + 8'd1;
                // The body is complete once count plus the two header bytes
                // reaches the length byte.
                if (({1'b0, count_next} + 9'd2) >= {1'b0, len_reg})
                begin
                    has_res    = 1'b1;
                    res        = finish_option(kind_reg, len_reg, cap_next, last);
                    phase_next = PH_KIND;
                end
                else if (last)
                begin
                    has_res           = 1'b1;
                    res.event_code    = EV_OVERRUN;
                    res.option_kind   = kind_reg;
                    res.option_length = len_reg;
                    res.ends_parse    = 1'b1;
                    phase_next        = PH_KIND;
                end
            end
            PH_STOP:
            begin
                if (last)
                begin
                    phase_next = PH_KIND;
                end
            end
            default:
            begin
                phase_next = PH_KIND;
            end
        endcase
    end

    assign res_load = take && has_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KIND;
            kind_reg  <= 8'd0;
            len_reg   <= 8'd0;
            count_reg <= 8'd0;
            cap_reg   <= 64'd0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

endmodule

@@ hdl/tcp_op_out_reg.sv @@
// ----------------------------------------------------------------------------
// Result register
// Holds one event until the downstream side takes it.
// ----------------------------------------------------------------------------
module tcp_op_out_reg
    import tcp_op_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  result_t        res,
    output logic           space,
    tcp_op_event_if.source evt_stream
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign space = !valid_reg || evt_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (evt_stream.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign evt_stream.valid         = valid_reg;
    assign evt_stream.event_code    = res_reg.event_code;
    assign evt_stream.option_kind   = res_reg.option_kind;
    assign evt_stream.option_length = res_reg.option_length;
    assign evt_stream.value_first   = res_reg.value_first;
    assign evt_stream.value_second  = res_reg.value_second;
    assign evt_stream.ends_parse    = res_reg.ends_parse;

endmodule

@@ hdl/tcp_option_parser_core.sv @@
// ----------------------------------------------------------------------------
// TCP option parser core
// Streaming parser of the TCP option area, one byte per item.
// ----------------------------------------------------------------------------
// The block takes one option byte per clock cycle while the event output does
// not stall, and emits at most one event per byte. A byte passes through the
// input register and its event through the result register, with the phase
// and option decode between them. A stalled event output holds the parser,
// and the input register keeps accepting until both registers are full.
module tcp_option_parser_core
    import tcp_op_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    tcp_op_byte_if.sink    opt_stream,
    tcp_op_event_if.source evt_stream
);

    logic    byte_valid;
    byte_t   byte_data;
    logic    take;
    logic    space;
    logic    res_load;
    result_t res;

    tcp_op_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .opt_stream (opt_stream),
        .take       (take),
        .valid      (byte_valid),
        .data       (byte_data)
    );

    tcp_op_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .space      (space),
        .take       (take),
        .res_load   (res_load),
        .res        (res)
    );

    tcp_op_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res_load),
        .res        (res),
        .space      (space),
        .evt_stream (evt_stream)
    );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP option parser core testbench
// Streams TCP option areas byte by byte into the parser and checks every
// event it emits against a behavioral mirror of the parse state. It covers
// directed corner cases, a pause in the middle of an option, and random areas
// that mix well-formed options with broken ones, under random stalls.
// ----------------------------------------------------------------------------
module tb;
    import tcp_op_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned RANDOM_ITEMS   = 620;
    localparam int unsigned TAIL_CYCLES    = 12;
    localparam int unsigned MAX_PRINTED    = 30;

    typedef logic [7:0] byte_q_t[$];

    logic clk;
    logic rst_n;

    tcp_op_byte_if  byte_ch();
    tcp_op_event_if evt_ch();

    tcp_option_parser_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .opt_stream (byte_ch),
        .evt_stream (evt_ch)
    );

    // Mirror of the parser state.
    phase_t      mdl_phase;
    logic [7:0]  mdl_kind;
    logic [7:0]  mdl_len;
    logic [7:0]  mdl_count;
    logic [63:0] mdl_capture;

    result_t     pending_events[$];
    int unsigned error_count;
    int unsigned mismatch_lines;
    int unsigned bytes_accepted;
    int unsigned bytes_parsed;
    int unsigned events_checked;
    int unsigned event_hits[16];
    int unsigned idle_cycles;
    int unsigned stall_left;
    bit          tx_steady;
    bit          rx_steady;

    always #2 clk = ~clk;

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic result_t make_event(input event_t code, input logic [7:0] kind,
                                           input logic [7:0] len, input logic ends);
        result_t ev;
        ev = '0;
        ev.event_code    = code;
        ev.option_kind   = kind;
        ev.option_length = len;
        ev.ends_parse    = ends;
        return ev;
    endfunction

    // Event for an option whose body is complete.
    function automatic result_t classify_option(input logic [7:0] kind, input logic [7:0] len,
                                                input logic [63:0] body, input logic ends);
        result_t ev;
        logic    length_ok;
        ev = make_event(EV_UNKNOWN, kind, len, ends);
        case (kind)
            KIND_MSS:    length_ok = (len == LEN_MSS);
            KIND_WSCALE: length_ok = (len == LEN_WSCALE);
            KIND_SACKOK: length_ok = (len == LEN_SACKOK);
            KIND_TS:     length_ok = (len == LEN_TS);
            default:     length_ok = 1'b1;
        endcase
        if (!length_ok)
        begin
            ev.event_code = EV_BADLEN;
        end
        else
        begin
            case (kind)
                KIND_MSS:
                begin
                    ev.event_code  = EV_MSS;
                    ev.value_first = {16'd0, body[15:0]};
                end
                KIND_WSCALE:
                begin
                    ev.event_code  = EV_WSCALE;
                    ev.value_first = {24'd0, body[7:0]};
                end
                KIND_SACKOK: ev.event_code = EV_SACKOK;
                KIND_SACK:   ev.event_code = EV_SACK;
                KIND_TS:
                begin
                    ev.event_code   = EV_TS;
                    ev.value_first  = body[63:32];
                    ev.value_second = body[31:0];
                end
                default:     ev.event_code = EV_UNKNOWN;
            endcase
        end
        return ev;
    endfunction

    // Advances the mirror by one byte; returns 1 when the byte causes an event.
    function automatic bit predict_option_event(input logic [7:0] b, input logic fin,
                                                output result_t ev);
        bit fires;
        fires = 1'b0;
        ev    = '0;
        case (mdl_phase)
            PH_KIND:
            begin
                if (b == KIND_EOL)
                begin
                    ev        = make_event(EV_EOL, KIND_EOL, 8'd0, 1'b1);
                    fires     = 1'b1;
                    mdl_phase = fin ? PH_KIND : PH_STOP;
                end
                else if (b == KIND_NOP)
                begin
                    ev    = make_event(EV_NOP, KIND_NOP, 8'd0, fin);
                    fires = 1'b1;
                end
                else if (fin)
                begin
                    ev    = make_event(EV_NOLEN, b, 8'd0, 1'b1);
                    fires = 1'b1;
                end
                else
                begin
                    mdl_kind  = b;
                    mdl_len   = 8'd0;
                    mdl_phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                mdl_len     = b;
                mdl_count   = 8'd0;
                mdl_capture = 64'd0;
                fires       = 1'b1;
                if (b < LEN_MIN)
                begin
                    ev        = make_event(EV_LENLT2, mdl_kind, b, 1'b1);
                    mdl_phase = fin ? PH_KIND : PH_STOP;
                end
                else if (b == LEN_MIN)
                begin
                    ev        = classify_option(mdl_kind, b, mdl_capture, fin);
                    mdl_phase = PH_KIND;
                end
                else if (fin)
                begin
                    ev        = make_event(EV_OVERRUN, mdl_kind, b, 1'b1);
                    mdl_phase = PH_KIND;
                end
                else
                begin
                    fires     = 1'b0;
                    mdl_phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                mdl_capture = {mdl_capture[55:0], b};
                mdl_count   = mdl_count + 8'd1;
                if ({1'b0, mdl_count} + 9'd2 >= {1'b0, mdl_len})
                begin
                    ev        = classify_option(mdl_kind, mdl_len, mdl_capture, fin);
                    fires     = 1'b1;
                    mdl_phase = PH_KIND;
                end
                else if (fin)
                begin
                    ev        = make_event(EV_OVERRUN, mdl_kind, mdl_len, 1'b1);
                    fires     = 1'b1;
                    mdl_phase = PH_KIND;
                end
            end
            default:
            begin
                if (fin)
                    mdl_phase = PH_KIND;
            end
        endcase
        return fires;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (mismatch_lines < MAX_PRINTED)
            $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_lines++;
    endtask

    task automatic check_event();
        result_t want;
        events_checked++;
        event_hits[evt_ch.event_code]++;
        if (pending_events.size() == 0)
        begin
            report_mismatch("event with nothing pending", 64'(evt_ch.event_code), 64'd0);
            return;
        end
        want = pending_events.pop_front();
        if (evt_ch.event_code !== want.event_code)
            report_mismatch("event_code", 64'(evt_ch.event_code), 64'(want.event_code));
        if (evt_ch.option_kind !== want.option_kind)
            report_mismatch("option_kind", 64'(evt_ch.option_kind), 64'(want.option_kind));
        if (evt_ch.option_length !== want.option_length)
            report_mismatch("option_length", 64'(evt_ch.option_length),
                            64'(want.option_length));
        if (evt_ch.value_first !== want.value_first)
            report_mismatch("value_first", 64'(evt_ch.value_first), 64'(want.value_first));
        if (evt_ch.value_second !== want.value_second)
            report_mismatch("value_second", 64'(evt_ch.value_second),
                            64'(want.value_second));
        if (evt_ch.ends_parse !== want.ends_parse)
            report_mismatch("ends_parse", 64'(evt_ch.ends_parse), 64'(want.ends_parse));
    endtask

    // Event side: check on each accepted item, then choose the next ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (evt_ch.valid && evt_ch.ready)
                check_event();
            if (stall_left != 0)
            begin
                evt_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                evt_ch.ready <= 1'b1;
                stall_left = rx_steady ? 0 : pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_ch.valid && byte_ch.ready) || (evt_ch.valid && evt_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", idle_cycles);
                $display("tcp_option_parser_core verification failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int unsigned gap;
        result_t     ev;
        gap = tx_steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.opt_byte  <= b;
        byte_ch.last_byte <= fin;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        bytes_accepted++;
        if (mdl_phase != PH_STOP)
            bytes_parsed++;
        if (predict_option_event(b, fin, ev))
            pending_events.push_back(ev);
    endtask

    task automatic send_area(input byte_q_t area);
        int unsigned i;
        for (i = 0; i < area.size(); i++)
            send_byte(area[i], i == area.size() - 1);
    endtask

    // Drops valid and holds until every expected event has come back.
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_events.size() != 0);
    endtask

    function automatic void append_random(ref byte_q_t area, input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            area.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic byte_q_t make_random_area();
        byte_q_t     area;
        int unsigned n_opts;
        int unsigned opt;
        int unsigned pick;
        int unsigned len;
        logic [7:0]  kind;
        logic [7:0]  good_len;
        bit          closed;
        area   = {};
        closed = 1'b0;
        n_opts = $urandom_range(1, 5);
        for (opt = 0; opt < n_opts && !closed; opt++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                area.push_back(KIND_NOP);
            end
            else if (pick < 20)
            begin
                area.push_back(KIND_MSS);
                area.push_back(LEN_MSS);
                append_random(area, 2);
            end
            else if (pick < 30)
            begin
                area.push_back(KIND_WSCALE);
                area.push_back(LEN_WSCALE);
                append_random(area, 1);
            end
            else if (pick < 38)
            begin
                area.push_back(KIND_SACKOK);
                area.push_back(LEN_SACKOK);
            end
            else if (pick < 50)
            begin
                len = 2 + 8 * $urandom_range(0, 4);
                area.push_back(KIND_SACK);
                area.push_back(8'(len));
                append_random(area, len - 2);
            end
            else if (pick < 64)
            begin
                area.push_back(KIND_TS);
                area.push_back(LEN_TS);
                append_random(area, 8);
            end
            else if (pick < 72)
            begin
                kind = 8'($urandom_range(6, 255));
                if (kind == KIND_TS)
                    kind = 8'd7;
                len = $urandom_range(2, 12);
                area.push_back(kind);
                area.push_back(8'(len));
                append_random(area, len - 2);
            end
            else if (pick < 80)
            begin
                // Known kind with a length it does not allow.
                case ($urandom_range(0, 3))
                    0:       kind = KIND_MSS;
                    1:       kind = KIND_WSCALE;
                    2:       kind = KIND_SACKOK;
                    default: kind = KIND_TS;
                endcase
                case (kind)
                    KIND_MSS:    good_len = LEN_MSS;
                    KIND_WSCALE: good_len = LEN_WSCALE;
                    KIND_SACKOK: good_len = LEN_SACKOK;
                    default:     good_len = LEN_TS;
                endcase
                do
                    len = $urandom_range(2, 14);
                while (len == good_len);
                area.push_back(kind);
                area.push_back(8'(len));
                append_random(area, len - 2);
            end
            else if (pick < 84)
            begin
                area.push_back(KIND_EOL);
                append_random(area, $urandom_range(0, 3));
                closed = 1'b1;
            end
            else if (pick < 88)
            begin
                area.push_back(8'($urandom_range(2, 255)));
                area.push_back(8'($urandom_range(0, 1)));
                append_random(area, $urandom_range(0, 3));
                closed = 1'b1;
            end
            else if (pick < 94)
            begin
                // The area ends before the option does.
                area.push_back(8'($urandom_range(2, 255)));
                if ($urandom_range(0, 3) != 0)
                begin
                    len = $urandom_range(3, 40);
                    area.push_back(8'(len));
                    append_random(area, $urandom_range(0, len - 3));
                end
                closed = 1'b1;
            end
            else
            begin
                append_random(area, $urandom_range(1, 6));
                closed = 1'b1;
            end
        end
        return area;
    endfunction

    task automatic test_directed_options();
        // No-op, MSS, window scale, SACK permitted, unknown kind, then an end of
        // list whose trailing bytes are ignored up to the last one, then a bad-length TS.
        send_area('{KIND_NOP, KIND_MSS, LEN_MSS, 8'hFF, 8'hFF, KIND_WSCALE, LEN_WSCALE,
                    8'h0E, KIND_SACKOK, LEN_SACKOK, 8'hFE, LEN_MIN, KIND_EOL, 8'h00, 8'hFF});
        send_area('{KIND_TS, 8'd3, 8'h55});
    endtask

    task automatic test_area_edges();
        send_area('{KIND_EOL});
        send_area('{8'hFF});
        send_area('{KIND_SACK, 8'd0});
        send_area('{KIND_WSCALE, 8'hFF});
        send_area('{KIND_SACK, 8'd6, 8'h80});
    endtask

    task automatic test_pause_mid_option();
        tx_steady = 1'b1;
        send_area('{KIND_NOP});
        send_byte(KIND_TS, 1'b0);
        send_byte(LEN_TS, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h23, 1'b0);
        send_byte(8'h45, 1'b0);
        wait_drained();
        tx_steady = 1'b0;
        send_byte(8'h67, 1'b0);
        send_byte(8'h89, 1'b0);
        send_byte(8'hAB, 1'b0);
        send_byte(8'hCD, 1'b0);
        send_byte(8'hEF, 1'b1);
    endtask

    task automatic test_random_areas();
        int unsigned goal;
        int unsigned areas;
        goal  = bytes_parsed + RANDOM_ITEMS;
        areas = 0;
        while (bytes_parsed < goal)
        begin
            // Change the idle pattern every few areas, including runs at full rate.
            if (areas % 6 == 0)
            begin
                tx_steady = ($urandom_range(0, 4) == 0);
                rx_steady = ($urandom_range(0, 4) == 0);
            end
            send_area(make_random_area());
            areas++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        int unsigned codes_seen;
        int unsigned code;
        clk               = 1'b0;
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.opt_byte  = 8'd0;
        byte_ch.last_byte = 1'b0;
        mdl_phase         = PH_KIND;
        mdl_kind          = 8'd0;
        mdl_len           = 8'd0;
        mdl_count         = 8'd0;
        mdl_capture       = 64'd0;
        error_count       = 0;
        mismatch_lines    = 0;
        bytes_accepted    = 0;
        bytes_parsed      = 0;
        events_checked    = 0;
        idle_cycles       = 0;
        tx_steady         = 1'b0;
        rx_steady         = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_options();
        test_area_edges();
        test_pause_mid_option();
        test_random_areas();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        codes_seen = 0;
        for (code = 0; code < 16; code++)
            if (event_hits[code] != 0)
                codes_seen++;
        $display("Sent %0d option bytes (%0d parsed), checked %0d events.",
                 bytes_accepted, bytes_parsed, events_checked);
        $display("Distinct event codes seen: %0d of 12, mismatches: %0d.",
                 codes_seen, error_count);
        if (error_count == 0 && pending_events.size() == 0)
            $display("tcp_option_parser_core verification clean");
        else
            $display("tcp_option_parser_core verification failed");
        $finish;
    end

endmodule
